>>> rtl/core/dirsel_pkg.sv
// Package for the nearest-angle direction select block.
// Holds the widths, constants, job and table-entry types shared by all modules but dirsel_ram.
// No dependencies.
`default_nettype none

package dirsel_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int TIDX_W      = ADDR_W + 1;
    localparam int SIZE_W      = 9;
    localparam int MAX_SLICE   = 32;
    localparam int LOC_W       = (MAX_SLICE > 1) ? $clog2(MAX_SLICE) : 1;

    // Field widths
    localparam int ANG_W   = 11;
    localparam int DIR_W   = 8;
    localparam int COUNT_W = 6;
    localparam int GRP_W   = 3;
    localparam int CFG_W   = 9;
    localparam int DIST_W  = ANG_W + 1;

    // Angle constants (2048 units per turn)
    localparam logic [DIST_W-1:0] ANG_TURN   = DIST_W'(2048);
    localparam logic [ANG_W-1:0]  ANG_HALF   = ANG_W'(1024);
    localparam logic [ANG_W-1:0]  LEG_OFFSET = ANG_W'(128);
    localparam logic [ANG_W-1:0]  FLIP_LOW   = ANG_W'(1151);
    localparam logic [ANG_W-1:0]  FLIP_HIGH  = ANG_W'(1919);
    localparam logic [GRP_W-1:0]  LEG_MID    = GRP_W'(4);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_TABLE_VALID = 1'b0;
    localparam logic CFG_TABLE_SIZE  = 1'b1;

    // Input function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_LEGACY = 2'd1,
        K_SEARCH = 2'd2
    } t_kind;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic             mirror;
        logic [DIR_W-1:0] src_dir;
    } t_entry;

    // Classified job handed from the front to the back
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;     // load index or slice first
        logic [ANG_W-1:0]   angle;    // entry angle or query angle
        logic               mirror;   // entry mirror or legacy flip
        logic [DIR_W-1:0]   src_dir;
        logic [COUNT_W-1:0] count;    // clamped slice count
        logic [GRP_W-1:0]   group;    // legacy group
    } t_job;

endpackage

`default_nettype wire

>>> rtl/core/dirsel_in_if.sv
// Input channel of the direction select block: valid/ready plus item fields.
// Depends on dirsel_pkg.
`default_nettype none

interface dirsel_in_if
    import dirsel_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               func;
    logic [7:0]         entry_index;
    logic [ANG_W-1:0]   entry_angle;
    logic               entry_mirror;
    logic [DIR_W-1:0]   entry_base_dir;
    logic [ANG_W-1:0]   query_angle;
    logic [7:0]         slice_first;
    logic [COUNT_W-1:0] slice_count;

    modport source (
        output valid, func, entry_index, entry_angle, entry_mirror, entry_base_dir,
               query_angle, slice_first, slice_count,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, entry_angle, entry_mirror, entry_base_dir,
               query_angle, slice_first, slice_count,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/dirsel_out_if.sv
// Result channel of the direction select block: valid/ready plus result fields.
// Depends on dirsel_pkg.
`default_nettype none

interface dirsel_out_if
    import dirsel_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] direction;
    logic             mirror;
    logic             used_legacy;

    modport source (
        output valid, direction, mirror, used_legacy,
        input  ready
    );
    modport sink (
        input  valid, direction, mirror, used_legacy,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/dirsel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dirsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/dirsel_queue.sv
// Short job queue between the front and the back of the direction select block.
// Depends on dirsel_pkg.
`default_nettype none

module dirsel_queue
    import dirsel_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_push_job,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_valid,
    output      t_job o_job
);

    t_job               r_slot [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and fill count
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dirsel_front.sv
// Front of the direction select block: accepts input transactions, classifies
// them as load, legacy select or table search, and pushes a job. Uses dirsel_pkg.
`default_nettype none

module dirsel_front
    import dirsel_pkg::*;
(
    dirsel_in_if.sink        i_in,
    input  wire logic        i_table_valid,
    input  wire logic        i_q_full,
    output      logic        o_push,
    output      t_job        o_job
);

    logic [ANG_W-1:0] shifted;
    logic [GRP_W-1:0] sector;
    logic [GRP_W-1:0] group;
    logic             flip;
    logic             legacy;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // Legacy five-group mapping with its x-flip band
    always_comb begin
        shifted = i_in.query_angle + LEG_OFFSET;
        sector  = shifted[ANG_W-1 -: GRP_W];
        group   = (sector <= LEG_MID) ? (LEG_MID - sector) : (sector - LEG_MID);
        flip    = (i_in.query_angle > FLIP_LOW) && (i_in.query_angle < FLIP_HIGH);
        legacy  = !i_table_valid || (i_in.slice_count == '0);
    end

    // Build the job
    always_comb begin
        o_job          = '0;
        o_job.group    = group;
        o_job.src_dir  = i_in.entry_base_dir;
        if (i_in.func == FUNC_LOAD) begin
            o_job.kind   = K_LOAD;
            o_job.addr   = ADDR_W'(i_in.entry_index);
            o_job.angle  = i_in.entry_angle;
            o_job.mirror = i_in.entry_mirror;
        end else if (legacy) begin
            o_job.kind   = K_LEGACY;
            o_job.mirror = flip;
        end else begin
            o_job.kind   = K_SEARCH;
            o_job.addr   = ADDR_W'(i_in.slice_first);
            o_job.angle  = i_in.query_angle;
            o_job.count  = (i_in.slice_count > COUNT_W'(MAX_SLICE)) ?
                           COUNT_W'(MAX_SLICE) : i_in.slice_count;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dirsel_back.sv
// Back of the direction select block: runs jobs in order, writes the table,
// scans a slice one entry per cycle and holds the result. Uses dirsel_pkg, dirsel_ram.
`default_nettype none

module dirsel_back
    import dirsel_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [SIZE_W-1:0] i_table_size,
    input  wire logic              i_q_valid,
    input  wire t_job              i_q_job,
    output      logic              o_pop,
    dirsel_out_if.source           o_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_job                r_job;
    logic [LOC_W-1:0]    r_loc;
    logic                r_rd_vld;
    logic [LOC_W-1:0]    r_rd_loc;
    logic [DIST_W-1:0]   r_best_dist;
    logic [LOC_W-1:0]    r_best_loc;
    logic                r_best_mir;
    logic [DIR_W-1:0]    r_best_base;
    logic                r_out_vld;
    logic [DIR_W-1:0]    r_out_dir;
    logic                r_out_mir;
    logic                r_out_leg;

    logic [TIDX_W-1:0]   idx;
    logic                usable;
    logic                last;
    logic                ram_we;
    t_entry              ram_wdata;
    t_entry              ram_rdata;
    logic [ANG_W-1:0]    diff;
    logic [DIST_W-1:0]   gap;
    logic                out_free;

    // Scan address and its range checks
    assign idx    = TIDX_W'(r_job.addr) + TIDX_W'(r_loc);
    assign usable = (SIZE_W'(idx) < i_table_size) && (idx < TIDX_W'(TABLE_DEPTH));
    assign last   = (COUNT_W'(r_loc) == r_job.count - 1'b1);

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign ram_we   = o_pop && (i_q_job.kind == K_LOAD);
    assign ram_wdata = '{angle: i_q_job.angle, mirror: i_q_job.mirror,
                         src_dir: i_q_job.src_dir};
    assign out_free = !r_out_vld || o_out.ready;

    dirsel_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_job.addr),
        .i_wdata (ram_wdata),
        .i_raddr (idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Wrapped angular distance to the returning entry
    always_comb begin
        diff = r_job.angle - ram_rdata.angle;
        gap  = (diff > ANG_HALF) ? (ANG_TURN - DIST_W'(diff)) : DIST_W'(diff);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_job.kind)
                        K_LEGACY: n_state = S_OUT;
                        K_SEARCH: n_state = S_SCAN;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN:  n_state = last ? S_FLUSH : S_SCAN;
            S_FLUSH: n_state = S_OUT;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN) && usable;
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Job latch, scan counter and best-candidate tracking
    always_ff @(posedge i_clk) begin
        r_rd_loc <= r_loc;
        if (o_pop) begin
            r_job       <= i_q_job;
            r_loc       <= '0;
            r_best_dist <= ANG_TURN;
            r_best_loc  <= '0;
            r_best_mir  <= 1'b0;
            r_best_base <= '0;
        end else begin
            if (r_state == S_SCAN && !last) begin
                r_loc <= r_loc + 1'b1;
            end
            if (r_rd_vld && (gap < r_best_dist)) begin
                r_best_dist <= gap;
                r_best_loc  <= r_rd_loc;
                r_best_mir  <= ram_rdata.mirror;
                r_best_base <= ram_rdata.src_dir;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            if (r_job.kind == K_LEGACY) begin
                r_out_dir <= DIR_W'(r_job.group);
                r_out_mir <= r_job.mirror;
                r_out_leg <= 1'b1;
            end else begin
                r_out_dir <= r_best_mir ? r_best_base : DIR_W'(r_best_loc);
                r_out_mir <= r_best_mir;
                r_out_leg <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.direction   = r_out_dir;
    assign o_out.mirror      = r_out_mir;
    assign o_out.used_legacy = r_out_leg;

endmodule

`default_nettype wire

>>> rtl/core/nearest_angle_direction_select.sv
// Nearest-angle direction select: holds a direction table and resolves a query
// angle to the nearest entry of a slice, or to the legacy five-group mapping.
//
// Channels: i_in carries load and select transactions (valid/ready), o_out
// carries one result per select transaction; loads give no result.
// Configuration: i_cfg_we with i_cfg_idx selects table_valid (index 0) or
// table_size (index 1); write only while no transaction is in flight.
// Timing: a transaction passes the front in the cycle it is accepted and waits
// in a two-entry queue. In the back a load is written to the table RAM as it
// leaves the queue; a legacy select goes to the output state, and a table search
// (count clamped to 32) scans the slice, reading one table entry per cycle through
// the table RAM's registered read port, then passes a flush and the output state.
// The result is held in an output register until taken. The back takes no new job
// while a select is in progress; loads leave the queue one per cycle while it is idle.
// Reset clears the configuration, the queue and the control state; table
// contents are undefined until written.
// When the receiver stalls, the held result blocks the back, the queue fills
// and i_in.ready drops.
`default_nettype none

module nearest_angle_direction_select
    import dirsel_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    dirsel_in_if.sink             i_in,
    dirsel_out_if.source          o_out
);

    logic              r_table_valid;
    logic [SIZE_W-1:0] r_table_size;
    logic              q_full;
    logic              q_push;
    t_job              q_push_job;
    logic              q_pop;
    logic              q_valid;
    t_job              q_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_valid <= 1'b0;
            r_table_size  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TABLE_VALID: r_table_valid <= i_cfg_data[0];
                CFG_TABLE_SIZE:  r_table_size  <= SIZE_W'(i_cfg_data);
                default:         r_table_valid <= r_table_valid;
            endcase
        end
    end

    dirsel_front u_front (
        .i_in          (i_in),
        .i_table_valid (r_table_valid),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (q_push_job)
    );

    dirsel_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (q_push_job),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_job      (q_job)
    );

    dirsel_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_table_size (r_table_size),
        .i_q_valid    (q_valid),
        .i_q_job      (q_job),
        .o_pop        (q_pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for nearest_angle_direction_select: a directed stimulus table, then random
// load and select transactions checked against a shadow copy of the direction table.
// Depends on dirsel_pkg, dirsel_in_if, dirsel_out_if and the block's RTL.

module testbench;
    import dirsel_pkg::*;

    localparam int TABLE_ENTRIES   = 256;
    localparam int SLICE_LIMIT     = 32;
    localparam int TURN            = 2048;
    localparam logic [ANG_W-1:0] LEGACY_OFFSET = 11'd128;
    localparam logic [ANG_W-1:0] FLIP_LO       = 11'd1151;
    localparam logic [ANG_W-1:0] FLIP_HI       = 11'd1919;
    localparam int DRAIN_CYCLES    = 100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int PHASE_ITEMS     = 215;
    localparam int PHASES          = 6;

    typedef struct packed {
        logic               func;
        logic [7:0]         entry_index;
        logic [ANG_W-1:0]   entry_angle;
        logic               entry_mirror;
        logic [DIR_W-1:0]   entry_base_dir;
        logic [ANG_W-1:0]   query_angle;
        logic [7:0]         slice_first;
        logic [COUNT_W-1:0] slice_count;
    } dir_item_t;

    typedef struct packed {
        logic [DIR_W-1:0] direction;
        logic             mirror;
        logic             used_legacy;
    } dir_pick_t;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_e;

    typedef struct packed {
        row_kind_e        kind;
        dir_item_t        item;
        logic             cfg_idx;
        logic [CFG_W-1:0] cfg_data;
        logic             known;
        dir_pick_t        pick;
    } stim_row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    dirsel_in_if  in_if();
    dirsel_out_if out_if();

    nearest_angle_direction_select dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Shadow state of the block
    t_entry    shadow_table [TABLE_ENTRIES];
    logic      cfg_valid;
    int        cfg_size;
    dir_pick_t expected_picks [$];
    int        mismatch_count;

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_off_req;
    bit hold_off_done;
    int hold_off_left;

    always #4 i_clk = ~i_clk;

    // Resolve a query against the shadow table and configuration
    function automatic dir_pick_t resolve_direction(logic [ANG_W-1:0] query,
                                                    logic [7:0] first,
                                                    logic [COUNT_W-1:0] count);
        dir_pick_t        r;
        logic [ANG_W-1:0] turned;
        logic [ANG_W-1:0] diff;
        int               sector;
        int               n;
        int               slot;
        int               gap;
        int               best;
        int               best_dist;
        r = '0;
        if (!cfg_valid || count == 0) begin
            turned        = query + LEGACY_OFFSET;
            sector        = int'(turned[10:8]);
            r.direction   = DIR_W'((sector <= 4) ? 4 - sector : sector - 4);
            r.mirror      = (query > FLIP_LO) && (query < FLIP_HI);
            r.used_legacy = 1'b1;
            return r;
        end
        n         = (int'(count) > SLICE_LIMIT) ? SLICE_LIMIT : int'(count);
        best      = 0;
        best_dist = TURN;
        for (int l = 0; l < n; l++) begin
            slot = int'(first) + l;
            if (slot < cfg_size && slot < TABLE_ENTRIES) begin
                diff = query - shadow_table[slot].angle;
                gap  = int'(diff);
                if (gap > TURN / 2)
                    gap = TURN - gap;
                // strict compare keeps the lowest index on a tie
                if (gap < best_dist) begin
                    best_dist = gap;
                    best      = l;
                end
            end
        end
        slot = int'(first) + best;
        if (slot < cfg_size && slot < TABLE_ENTRIES && shadow_table[slot].mirror) begin
            r.direction = shadow_table[slot].src_dir;
            r.mirror    = 1'b1;
        end else begin
            r.direction = DIR_W'(best);
            r.mirror    = 1'b0;
        end
        r.used_legacy = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t load_row(int idx, int ang, bit mir, int base);
        stim_row_t r;
        r                     = '0;
        r.kind                = ROW_ITEM;
        r.item.func           = FUNC_LOAD;
        r.item.entry_index    = 8'(idx);
        r.item.entry_angle    = ANG_W'(ang);
        r.item.entry_mirror   = mir;
        r.item.entry_base_dir = DIR_W'(base);
        r.item.query_angle    = ANG_W'($urandom);
        r.item.slice_first    = 8'($urandom);
        r.item.slice_count    = COUNT_W'($urandom);
        return r;
    endfunction

    function automatic stim_row_t pick_row(int query, int first, int count);
        stim_row_t r;
        r                     = '0;
        r.kind                = ROW_ITEM;
        r.item.func           = FUNC_SELECT;
        r.item.entry_index    = 8'($urandom);
        r.item.entry_angle    = ANG_W'($urandom);
        r.item.entry_mirror   = 1'($urandom);
        r.item.entry_base_dir = DIR_W'($urandom);
        r.item.query_angle    = ANG_W'(query);
        r.item.slice_first    = 8'(first);
        r.item.slice_count    = COUNT_W'(count);
        return r;
    endfunction

    function automatic stim_row_t known_row(int query, int first, int count,
                                            int dir, bit mir, bit leg);
        stim_row_t r;
        r                    = pick_row(query, first, count);
        r.known              = 1'b1;
        r.pick.direction     = DIR_W'(dir);
        r.pick.mirror        = mir;
        r.pick.used_legacy   = leg;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic idx, int data);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = CFG_W'(data);
        return r;
    endfunction

    // Offer one transaction, wait for acceptance, then update the shadow state
    task automatic send_item(input dir_item_t item, input logic known, input dir_pick_t pick);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.func           <= item.func;
        in_if.entry_index    <= item.entry_index;
        in_if.entry_angle    <= item.entry_angle;
        in_if.entry_mirror   <= item.entry_mirror;
        in_if.entry_base_dir <= item.entry_base_dir;
        in_if.query_angle    <= item.query_angle;
        in_if.slice_first    <= item.slice_first;
        in_if.slice_count    <= item.slice_count;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        if (item.func == FUNC_LOAD) begin
            shadow_table[item.entry_index].angle   = item.entry_angle;
            shadow_table[item.entry_index].mirror  = item.entry_mirror;
            shadow_table[item.entry_index].src_dir = item.entry_base_dir;
        end else if (known) begin
            expected_picks.push_back(pick);
        end else begin
            expected_picks.push_back(resolve_direction(item.query_angle, item.slice_first,
                                                       item.slice_count));
        end
    endtask

    // Drop valid, wait for every result, then let trailing loads finish
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_TABLE_VALID)
            cfg_valid = data[0];
        else
            cfg_size = int'(data);
    endtask

    // Drive the receiver's ready, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_req && !hold_off_done) begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
        end
        if (hold_off_left > 0) begin
            out_if.ready  <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            out_if.ready  <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        dir_pick_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_picks.size() == 0) begin
                $error("unexpected result: direction %0d mirror %0d used_legacy %0d",
                       out_if.direction, out_if.mirror, out_if.used_legacy);
                mismatch_count++;
            end else begin
                want = expected_picks.pop_front();
                if (out_if.direction !== want.direction) begin
                    $error("direction: expected %0d, actual %0d",
                           want.direction, out_if.direction);
                    mismatch_count++;
                end
                if (out_if.mirror !== want.mirror) begin
                    $error("mirror: expected %0d, actual %0d", want.mirror, out_if.mirror);
                    mismatch_count++;
                end
                if (out_if.used_legacy !== want.used_legacy) begin
                    $error("used_legacy: expected %0d, actual %0d",
                           want.used_legacy, out_if.used_legacy);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : main
        stim_row_t directed_rows [$];
        dir_item_t item;
        bit        phase_valid [PHASES];
        int        phase_size [PHASES];
        int        roll;

        // Known values on every input from time zero
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_TABLE_VALID;
        i_cfg_data           = '0;
        in_if.valid          = 1'b0;
        in_if.func           = FUNC_LOAD;
        in_if.entry_index    = '0;
        in_if.entry_angle    = '0;
        in_if.entry_mirror   = 1'b0;
        in_if.entry_base_dir = '0;
        in_if.query_angle    = '0;
        in_if.slice_first    = '0;
        in_if.slice_count    = '0;
        out_if.ready         = 1'b0;
        cfg_valid            = 1'b0;
        cfg_size             = 0;
        mismatch_count       = 0;
        hold_off_req         = 1'b0;
        hold_off_done        = 1'b0;
        hold_off_left        = 0;
        tx_idle_pct          = 6;
        rx_idle_pct          = 73;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_rows = '{
            // legacy mapping with the table still invalid after reset
            known_row(0,    0,   0,  4, 0, 1),
            known_row(2047, 255, 63, 4, 0, 1),
            known_row(1151, 0,   0,  0, 0, 1),
            known_row(1152, 0,   0,  1, 1, 1),
            known_row(1918, 0,   0,  3, 1, 1),
            known_row(1919, 0,   0,  3, 0, 1),
            known_row(1920, 0,   0,  4, 0, 1),
            known_row(128,  0,   0,  3, 0, 1),
            // fill the first entries and the last one
            load_row(0,   0,    0, 8'h00),
            load_row(1,   512,  0, 8'h55),
            load_row(2,   1024, 1, 8'hFF),
            load_row(3,   1536, 1, 8'h00),
            load_row(4,   2047, 0, 8'hFF),
            load_row(5,   256,  0, 8'hAA),
            load_row(6,   768,  1, 8'h81),
            load_row(7,   1792, 1, 8'hAA),
            load_row(255, 2047, 1, 8'hFF),
            cfg_row(CFG_TABLE_VALID, 1),
            cfg_row(CFG_TABLE_SIZE, 8),
            // table search in and beyond the configured size, and a zero-count legacy select
            pick_row(0,    0,   8),
            pick_row(256,  0,   2),
            known_row(1030, 0,  8,  8'hFF, 1, 0),
            pick_row(1,    3,   2),
            pick_row(700,  0,   63),
            known_row(500, 8,   5,  0, 0, 0),
            pick_row(1900, 6,   32),
            known_row(896, 0,   0,  0, 0, 1),
            known_row(2047, 255, 1, 0, 0, 0)
        };

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_data);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].known,
                          directed_rows[i].pick);
            end
        end

        // Write every entry so that no later search reads an unwritten one
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            item                = '0;
            item.func           = FUNC_LOAD;
            item.entry_index    = 8'(e);
            item.entry_angle    = ($urandom_range(0, 99) < 40) ?
                                  ANG_W'($urandom_range(0, 7) * 256) : ANG_W'($urandom);
            item.entry_mirror   = 1'($urandom);
            item.entry_base_dir = DIR_W'($urandom);
            item.query_angle    = ANG_W'($urandom);
            item.slice_first    = 8'($urandom);
            item.slice_count    = COUNT_W'($urandom);
            send_item(item, 1'b0, '0);
        end

        phase_valid = '{1, 1, 0, 1, 1, 1};
        phase_size  = '{256, $urandom_range(2, 254), 256, 1, 0, 255};

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p / 2)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 73;
                end
                1: begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_reg(CFG_TABLE_VALID, CFG_W'(phase_valid[p]));
            write_reg(CFG_TABLE_SIZE, CFG_W'(phase_size[p]));
            // stall the receiver while the sender keeps pushing
            if (p == 4)
                hold_off_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                item.func           = ($urandom_range(0, 99) < 30) ? FUNC_LOAD : FUNC_SELECT;
                item.entry_index    = 8'($urandom);
                item.entry_angle    = ($urandom_range(0, 99) < 40) ?
                                      ANG_W'($urandom_range(0, 7) * 256) : ANG_W'($urandom);
                item.entry_mirror   = 1'($urandom);
                item.entry_base_dir = DIR_W'($urandom);
                // near a multiple of 128 to land on ties and sector edges
                item.query_angle    = ($urandom_range(0, 1) == 0) ? ANG_W'($urandom) :
                                      ANG_W'($urandom_range(0, 15) * 128 +
                                             $urandom_range(0, 4) - 2);
                item.slice_first    = 8'($urandom);
                roll                = $urandom_range(0, 99);
                if (roll < 5)
                    item.slice_count = '0;
                else if (roll < 12)
                    item.slice_count = COUNT_W'($urandom_range(33, 63));
                else
                    item.slice_count = COUNT_W'($urandom_range(1, 32));
                send_item(item, 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
